>>> hw/rtl/iolh_pkg.sv
// iolh_pkg: sizes, widths and codes shared by the I/O latency histogram core.
// No dependencies. Used by io_latency_log2_histogram_core and iolh_checker.
package iolh_pkg;

  // Sizing
  localparam int TABLE_DEPTH = 64;   // outstanding request table entries
  localparam int NUM_BUCKETS = 27;   // log2 histogram buckets
  localparam int COUNT_WIDTH = 32;   // bucket counter width

  // Field widths
  localparam int OP_W     = 2;
  localparam int DEV_W    = 32;
  localparam int SEC_W    = 64;
  localparam int TIME_W   = 64;
  localparam int IDX_W    = 5;
  localparam int STATUS_W = 3;
  localparam int BUCKET_W = 5;
  localparam int OCOUNT_W = 32;

  // Derived widths
  localparam int TAW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W   = TAW + 1;
  localparam int BW      = $clog2(NUM_BUCKETS);
  localparam int ENTRY_W = DEV_W + SEC_W + TIME_W;

  // ns per us; the bucket threshold 1000 << k needs up to 10 + NUM_BUCKETS bits
  localparam int NS_PER_US = 1000;
  localparam int THR_W     = (10 + NUM_BUCKETS > TIME_W) ? 10 + NUM_BUCKETS : TIME_W;

  // Op codes
  localparam logic [OP_W-1:0] OP_ISSUE    = 2'd0;
  localparam logic [OP_W-1:0] OP_COMPLETE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ     = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE     = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_STORED    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RECORDED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UNMATCHED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NONPOS    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_READ_DONE = 3'd5;

endpackage

>>> hw/rtl/iolh_ram.sv
// iolh_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module iolh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/io_latency_log2_histogram_core.sv
// Sequence, accept edge to out_valid: issue scans the table (one RAM read per cycle), then loads
// the output register; complete scans, forms the delta (a nonpositive one goes straight to the
// output), runs the log2 steps, reads and updates the bucket counter and loads the output; read
// fetches the bucket, or past the last bucket goes straight to the output. One item at a time;
// a key match ends the scan early, and a stalled result delays the next result. Reset
// (synchronous, rst_n low) clears table and bucket valid bits; no clearing pass. Uses iolh_pkg, iolh_ram.
module io_latency_log2_histogram_core
  import iolh_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OP_W-1:0]     in_op,
  input  logic [DEV_W-1:0]    in_dev,
  input  logic [SEC_W-1:0]    in_sector,
  input  logic [TIME_W-1:0]   in_time_ns,
  input  logic [IDX_W-1:0]    in_bucket_index,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [BUCKET_W-1:0] out_bucket,
  output logic [OCOUNT_W-1:0] out_count
);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DELTA, S_LOG, S_BRD, S_BUPD, S_RESP
  } state_t;

  state_t state_r, state_nxt;

  // Latched item
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [DEV_W-1:0]  dev_r, dev_nxt;
  logic [SEC_W-1:0]  sec_r, sec_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;

  // Table scan
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             cmp_vld_r, cmp_vld_nxt;
  logic [TAW-1:0]   cmp_idx_r, cmp_idx_nxt;
  logic             free_fnd_r, free_fnd_nxt;
  logic [TAW-1:0]   free_idx_r, free_idx_nxt;
  logic [TABLE_DEPTH-1:0] ent_vld_r, ent_vld_nxt;

  // Latency and bucket search
  logic [TIME_W-1:0] start_r, start_nxt;
  logic [TIME_W-1:0] d_r, d_nxt;
  logic [THR_W-1:0]  thr_r, thr_nxt;
  logic [BW-1:0]     k_r, k_nxt;
  logic [BW-1:0]     b_r, b_nxt;
  logic [NUM_BUCKETS-1:0] bkt_vld_r, bkt_vld_nxt;

  // Pending result and output register
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [BUCKET_W-1:0] res_bucket_r, res_bucket_nxt;
  logic [OCOUNT_W-1:0] res_count_r, res_count_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [BUCKET_W-1:0] out_bucket_r, out_bucket_nxt;
  logic [OCOUNT_W-1:0] out_count_r, out_count_nxt;

  // RAM ports
  logic               ent_we;
  logic [TAW-1:0]     ent_waddr;
  logic [ENTRY_W-1:0] ent_wdata, ent_rdata;
  logic                   bkt_we;
  logic [COUNT_WIDTH-1:0] bkt_rdata, bkt_cur, cnt_inc;

  // Compare stage decode
  logic [DEV_W-1:0]  rd_dev;
  logic [SEC_W-1:0]  rd_sec;
  logic [TIME_W-1:0] rd_time;
  logic key_hit, scan_end, slot_free;

  iolh_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (cnt_r[TAW-1:0]),
    .rdata (ent_rdata)
  );

  iolh_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(NUM_BUCKETS)) u_bkt_ram (
    .clk   (clk),
    .we    (bkt_we),
    .waddr (b_r),
    .wdata (cnt_inc),
    .raddr (b_r),
    .rdata (bkt_rdata)
  );

  assign rd_dev  = ent_rdata[ENTRY_W-1 -: DEV_W];
  assign rd_sec  = ent_rdata[SEC_W+TIME_W-1 -: SEC_W];
  assign rd_time = ent_rdata[TIME_W-1:0];

  assign key_hit   = cmp_vld_r && ent_vld_r[cmp_idx_r] && (rd_dev == dev_r) && (rd_sec == sec_r);
  assign scan_end  = cmp_vld_r && (cmp_idx_r == TAW'(TABLE_DEPTH - 1));
  assign slot_free = cmp_vld_r && !ent_vld_r[cmp_idx_r];

  // Saturating counter increment; unwritten buckets read as zero
  assign bkt_cur = bkt_vld_r[b_r] ? bkt_rdata : '0;
  assign cnt_inc = (&bkt_cur) ? bkt_cur : bkt_cur + 1'b1;

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_bucket = out_bucket_r;
  assign out_count  = out_count_r;

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    dev_nxt        = dev_r;
    sec_nxt        = sec_r;
    now_nxt        = now_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    cmp_vld_nxt    = cmp_vld_r;
    cmp_idx_nxt    = cmp_idx_r;
    free_fnd_nxt   = free_fnd_r;
    free_idx_nxt   = free_idx_r;
    ent_vld_nxt    = ent_vld_r;
    start_nxt      = start_r;
    d_nxt          = d_r;
    thr_nxt        = thr_r;
    k_nxt          = k_r;
    b_nxt          = b_r;
    bkt_vld_nxt    = bkt_vld_r;
    res_status_nxt = res_status_r;
    res_bucket_nxt = res_bucket_r;
    res_count_nxt  = res_count_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_bucket_nxt = out_bucket_r;
    out_count_nxt  = out_count_r;
    ent_we         = 1'b0;
    ent_waddr      = cmp_idx_r;
    ent_wdata      = {dev_r, sec_r, now_r};
    bkt_we         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt  = in_op;
          dev_nxt = in_dev;
          sec_nxt = in_sector;
          now_nxt = in_time_ns;
          idx_nxt = in_bucket_index;
          case (in_op)
            OP_ISSUE, OP_COMPLETE: begin
              cnt_nxt      = '0;
              cmp_vld_nxt  = 1'b0;
              free_fnd_nxt = 1'b0;
              state_nxt    = S_SCAN;
            end
            OP_READ: begin
              b_nxt = BW'(in_bucket_index);
              if (32'(in_bucket_index) < NUM_BUCKETS) begin
                state_nxt = S_BRD;
              end else begin
                res_status_nxt = ST_READ_DONE;
                res_bucket_nxt = BUCKET_W'(in_bucket_index);
                res_count_nxt  = '0;
                state_nxt      = S_RESP;
              end
            end
            default: ;  // unused op: no result
          endcase
        end
      end

      S_SCAN: begin
        // read stage: one entry address per cycle
        if (cnt_r < CNT_W'(TABLE_DEPTH)) begin
          cnt_nxt     = cnt_r + 1'b1;
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = cnt_r[TAW-1:0];
        end else begin
          cmp_vld_nxt = 1'b0;
        end
        // remember lowest free entry
        if (slot_free && !free_fnd_r) begin
          free_fnd_nxt = 1'b1;
          free_idx_nxt = cmp_idx_r;
        end
        res_bucket_nxt = '0;
        res_count_nxt  = '0;
        if (key_hit) begin
          if (op_r == OP_ISSUE) begin
            // existing key: refresh issue time
            ent_we         = 1'b1;
            res_status_nxt = ST_STORED;
            state_nxt      = S_RESP;
          end else begin
            ent_vld_nxt[cmp_idx_r] = 1'b0;
            start_nxt              = rd_time;
            state_nxt              = S_DELTA;
          end
        end else if (scan_end) begin
          if (op_r == OP_ISSUE) begin
            if (free_fnd_r || slot_free) begin
              ent_we                 = 1'b1;
              ent_waddr              = free_fnd_r ? free_idx_r : cmp_idx_r;
              ent_vld_nxt[ent_waddr] = 1'b1;
              res_status_nxt         = ST_STORED;
            end else begin
              res_status_nxt = ST_FULL;
            end
          end else begin
            res_status_nxt = ST_UNMATCHED;
          end
          state_nxt = S_RESP;
        end
      end

      S_DELTA: begin
        if (now_r <= start_r) begin
          res_status_nxt = ST_NONPOS;
          res_bucket_nxt = '0;
          res_count_nxt  = '0;
          state_nxt      = S_RESP;
        end else begin
          d_nxt     = now_r - start_r;
          k_nxt     = BW'(1);
          thr_nxt   = THR_W'(2 * NS_PER_US);
          b_nxt     = '0;
          state_nxt = S_LOG;
        end
      end

      // bucket = largest k with 1000 << k <= delta, or 0 if none, clamped to the last bucket
      S_LOG: begin
        if (THR_W'(d_r) >= thr_r) begin
          b_nxt = k_r;
          if (k_r == BW'(NUM_BUCKETS - 1)) begin
            state_nxt = S_BRD;
          end else begin
            k_nxt   = k_r + 1'b1;
            thr_nxt = thr_r << 1;
          end
        end else begin
          state_nxt = S_BRD;
        end
      end

      S_BRD: begin
        state_nxt = S_BUPD;
      end

      S_BUPD: begin
        if (op_r == OP_READ) begin
          res_status_nxt = ST_READ_DONE;
          res_bucket_nxt = BUCKET_W'(idx_r);
          res_count_nxt  = OCOUNT_W'(bkt_cur);
        end else begin
          bkt_we           = 1'b1;
          bkt_vld_nxt[b_r] = 1'b1;
          res_status_nxt   = ST_RECORDED;
          res_bucket_nxt   = BUCKET_W'(b_r);
          res_count_nxt    = OCOUNT_W'(cnt_inc);
        end
        state_nxt = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_bucket_nxt = res_bucket_r;
          out_count_nxt  = res_count_r;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // State, control and payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cmp_vld_r   <= 1'b0;
      free_fnd_r  <= 1'b0;
      ent_vld_r   <= '0;
      bkt_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      free_fnd_r  <= free_fnd_nxt;
      ent_vld_r   <= ent_vld_nxt;
      bkt_vld_r   <= bkt_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    dev_r        <= dev_nxt;
    sec_r        <= sec_nxt;
    now_r        <= now_nxt;
    idx_r        <= idx_nxt;
    cnt_r        <= cnt_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    free_idx_r   <= free_idx_nxt;
    start_r      <= start_nxt;
    d_r          <= d_nxt;
    thr_r        <= thr_nxt;
    k_r          <= k_nxt;
    b_r          <= b_nxt;
    res_status_r <= res_status_nxt;
    res_bucket_r <= res_bucket_nxt;
    res_count_r  <= res_count_nxt;
    out_status_r <= out_status_nxt;
    out_bucket_r <= out_bucket_nxt;
    out_count_r  <= out_count_nxt;
  end

endmodule

>>> hw/rtl/iolh_checker.sv
// iolh_checker: port-level assertions for io_latency_log2_histogram_core, bound below.
// Depends on iolh_pkg.
module iolh_checker
  import iolh_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic [OP_W-1:0]     in_op,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] out_status,
  input logic [BUCKET_W-1:0] out_bucket,
  input logic [OCOUNT_W-1:0] out_count
);

  // A stalled result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_bucket)
      && $stable(out_count))
    else $error("result changed while stalled");

  // Any real op occupies the block for at least the next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op != OP_NONE) |=> !in_ready)
    else $error("ready after accepting a real op");

  // Unused op is dropped at once
  a_nop: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op == OP_NONE) |=> in_ready)
    else $error("unused op stalled the block");

  // Table outcomes carry no bucket or count
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_status == ST_STORED) || (out_status == ST_FULL)
      || (out_status == ST_UNMATCHED) || (out_status == ST_NONPOS))
      |-> (out_bucket == '0) && (out_count == '0))
    else $error("nonzero bucket or count on table status");

  // Only defined status codes appear
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_READ_DONE)
    else $error("undefined status code");

endmodule

bind io_latency_log2_histogram_core iolh_checker u_iolh_checker (.*);
